// ===== sv/dcs_pkg.sv =====
// Shared constants and types for the DNA codeword screen.
`timescale 1ns / 1ps

package dcs_pkg;

  localparam int NUM_PARTS = 6;
  localparam int CODEWORD_W = 16;
  localparam int CODEWORD_LETTERS = CODEWORD_W / 2;
  localparam int WORD_LETTERS_DEF = 8;

  localparam int GC_COUNT_W = 5;
  localparam int STEM_W = 4;
  localparam int UNIT_W = 4;
  localparam int LIMIT_W = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_INDEX_W = 3;

  typedef logic [1:0] letter_t;
  typedef logic [NUM_PARTS-1:0] part_mask_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_GC_LOW = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GC_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_STEM = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_UNIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_LIMIT = 3'd4;

  localparam logic [GC_COUNT_W-1:0] GC_LOW_RESET = 5'd3;
  localparam logic [GC_COUNT_W-1:0] GC_HIGH_RESET = 5'd5;
  localparam logic [STEM_W-1:0] MIN_STEM_RESET = 4'd3;
  localparam logic [UNIT_W-1:0] MAX_UNIT_RESET = 4'd4;
  localparam logic [LIMIT_W-1:0] REPEAT_LIMIT_RESET = 5'd4;

  // Letter codes are A=0, C=1, G=2, T=3, so the complement is the bitwise inverse.
  localparam letter_t PART_MAP [NUM_PARTS][4] = '{
    '{2'd2, 2'd1, 2'd0, 2'd3},
    '{2'd2, 2'd3, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd2, 2'd0, 2'd3, 2'd1},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd0, 2'd3, 2'd2, 2'd1}
  };

endpackage

// ===== sv/dna_codeword_screen_unit.sv =====
// Top level of the DNA codeword screen: input register, screening logic, result register.
//
//   channel | signals                                    | transfer when
//   --------+--------------------------------------------+----------------------
//   in      | in_valid, in_stall, codeword               | in_valid & !in_stall
//   out     | out_valid, out_stall, gc_reject_mask,      | out_valid & !out_stall
//           | hairpin_reject_mask, repeat_reject,        |
//           | reject_mask                                |
//   cfg     | cfg_we, cfg_index, cfg_data                | cfg_we
//
// One codeword per cycle unless stalled; a result passes input and result registers.
// The screen is one pass of comparator trees between the input and result registers.
// Reset clears both valid flags and loads the register defaults.
// A stalled result holds; an empty input register still takes one more codeword behind it.
`timescale 1ns / 1ps

module dna_codeword_screen_unit #(
  parameter int WORD_LETTERS = dcs_pkg::WORD_LETTERS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [dcs_pkg::CODEWORD_W-1:0] codeword,
  output logic out_valid,
  input  logic out_stall,
  output dcs_pkg::part_mask_t gc_reject_mask,
  output dcs_pkg::part_mask_t hairpin_reject_mask,
  output logic repeat_reject,
  output dcs_pkg::part_mask_t reject_mask,
  input  logic cfg_we,
  input  logic [dcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dcs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NP = dcs_pkg::NUM_PARTS;
  localparam int CNT_W = $clog2(WORD_LETTERS + 1);
  localparam int HALF_LETTERS = WORD_LETTERS / 2;

  logic [dcs_pkg::GC_COUNT_W-1:0] gc_low_count;
  logic [dcs_pkg::GC_COUNT_W-1:0] gc_high_count;
  logic [dcs_pkg::STEM_W-1:0] min_stem;
  logic [dcs_pkg::UNIT_W-1:0] max_repeat_unit;
  logic [dcs_pkg::LIMIT_W-1:0] repeat_limit;

  logic s1_valid;
  logic [dcs_pkg::CODEWORD_W-1:0] s1_codeword;
  logic advance;

  dcs_pkg::letter_t digits [WORD_LETTERS];
  dcs_pkg::letter_t letters [NP][WORD_LETTERS];
  logic [CNT_W-1:0] gc_count [NP];
  dcs_pkg::part_mask_t gc_next;
  dcs_pkg::part_mask_t hp_next;
  logic rep_next;
  logic blk_eq [WORD_LETTERS+1][WORD_LETTERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      gc_low_count <= dcs_pkg::GC_LOW_RESET;
      gc_high_count <= dcs_pkg::GC_HIGH_RESET;
      min_stem <= dcs_pkg::MIN_STEM_RESET;
      max_repeat_unit <= dcs_pkg::MAX_UNIT_RESET;
      repeat_limit <= dcs_pkg::REPEAT_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dcs_pkg::CFG_GC_LOW: gc_low_count <= cfg_data;
        dcs_pkg::CFG_GC_HIGH: gc_high_count <= cfg_data;
        dcs_pkg::CFG_MIN_STEM: min_stem <= cfg_data[dcs_pkg::STEM_W-1:0];
        dcs_pkg::CFG_MAX_UNIT: max_repeat_unit <= cfg_data[dcs_pkg::UNIT_W-1:0];
        dcs_pkg::CFG_REPEAT_LIMIT: repeat_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_codeword <= codeword;
    end
  end

  // Letters past the codeword read as digit zero.
  for (genvar j = 0; j < WORD_LETTERS; j++) begin : g_digit
    if (j < dcs_pkg::CODEWORD_LETTERS) begin : g_in
      assign digits[j] = s1_codeword[2*j +: 2];
    end else begin : g_pad
      assign digits[j] = 2'd0;
    end
  end

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      gc_count[p] = '0;
      for (int j = 0; j < WORD_LETTERS; j++) begin
        letters[p][j] = dcs_pkg::PART_MAP[p][digits[j]];
        gc_count[p] = gc_count[p] + CNT_W'(letters[p][j][1] ^ letters[p][j][0]);
      end
      gc_next[p] = (dcs_pkg::GC_COUNT_W'(gc_count[p]) < gc_low_count) ||
                   (dcs_pkg::GC_COUNT_W'(gc_count[p]) > gc_high_count);
    end
  end

  // A stem of size s at start l and gap d matches when each stem letter is the
  // complement of its mirror letter across the gap.
  always_comb begin
    logic eq;
    eq = 1'b0;
    for (int p = 0; p < NP; p++) begin
      hp_next[p] = (min_stem == '0);
      for (int s = 1; s <= HALF_LETTERS; s++) begin
        for (int d = 1; d <= WORD_LETTERS - 2 * s; d++) begin
          for (int l = 0; l <= WORD_LETTERS - d - 2 * s; l++) begin
            eq = 1'b1;
            for (int i = 0; i < s; i++) begin
              if (letters[p][l+s-1-i] != ~letters[p][l+s+d+i]) begin
                eq = 1'b0;
              end
            end
            if (eq && (s >= int'(min_stem))) begin
              hp_next[p] = 1'b1;
            end
          end
        end
      end
    end
  end

  // A run of m equal aligned blocks of r letters is m*r letters long.
  always_comb begin
    logic win;
    logic long_enough;
    win = 1'b0;
    long_enough = 1'b0;
    rep_next = 1'b0;
    for (int r = 1; r <= WORD_LETTERS; r++) begin
      for (int b = 0; b < WORD_LETTERS; b++) begin
        blk_eq[r][b] = 1'b0;
        if (b >= 1 && (b + 1) * r <= WORD_LETTERS) begin
          blk_eq[r][b] = 1'b1;
          for (int i = 0; i < r; i++) begin
            if (digits[b*r+i] != digits[(b-1)*r+i]) begin
              blk_eq[r][b] = 1'b0;
            end
          end
        end
      end
    end
    for (int r = 0; r <= WORD_LETTERS; r++) begin
      for (int b = 0; b < WORD_LETTERS; b++) begin
        if (r == 0) begin
          blk_eq[r][b] = 1'b0;
        end
      end
    end
    for (int r = 1; r <= WORD_LETTERS; r++) begin
      if (r <= int'(max_repeat_unit)) begin
        for (int m = 1; m * r <= WORD_LETTERS; m++) begin
          if (r == 1) begin
            long_enough = (m >= int'(repeat_limit));
          end else begin
            long_enough = (m * r > int'(repeat_limit));
          end
          for (int b = 0; (b + m) * r <= WORD_LETTERS; b++) begin
            win = 1'b1;
            for (int k = 1; k < m; k++) begin
              if (!blk_eq[r][b+k]) begin
                win = 1'b0;
              end
            end
            if (win && long_enough) begin
              rep_next = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      gc_reject_mask <= gc_next;
      hairpin_reject_mask <= hp_next;
      repeat_reject <= rep_next;
      reject_mask <= gc_next | hp_next | {NP{rep_next}};
    end
  end

endmodule

// ===== sv/dcs_checker.sv =====
// Port-level checks for the DNA codeword screen and their binding to the top level.
`timescale 1ns / 1ps

module dcs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input dcs_pkg::part_mask_t gc_reject_mask,
  input dcs_pkg::part_mask_t hairpin_reject_mask,
  input logic repeat_reject,
  input dcs_pkg::part_mask_t reject_mask
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_mask_union: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reject_mask ==
      (gc_reject_mask | hairpin_reject_mask | {dcs_pkg::NUM_PARTS{repeat_reject}}))
    else $error("combined mask differs from its parts");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result side is free");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a transfer two cycles earlier");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind dna_codeword_screen_unit dcs_checker u_dcs_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .gc_reject_mask(gc_reject_mask),
  .hairpin_reject_mask(hairpin_reject_mask),
  .repeat_reject(repeat_reject),
  .reject_mask(reject_mask)
);
